>>> sv/stop_and_wait_retransmit_core_defines.svh
// Assertion macros shared by the stop-and-wait sender RTL.
`ifndef STOP_AND_WAIT_RETRANSMIT_CORE_DEFINES_SVH
`define STOP_AND_WAIT_RETRANSMIT_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SWR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swr assertion failed");

// Next-cycle implication, checked outside reset.
`define SWR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swr assertion failed");

`endif

>>> sv/swr_pkg.sv
// Types and constants of the stop-and-wait sender.
package swr_pkg;

  localparam int unsigned NUM_W     = 32;
  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned RETRY_W   = 4;
  localparam int unsigned ATTEMPT_W = 5;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd500;
  localparam logic [RETRY_W-1:0]   RETRY_RST   = 4'd3;
  localparam logic [NUM_W-1:0]     SEQ_FIRST   = 32'd1;
  localparam logic [TIMEOUT_W-1:0] ELAPSED_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_SEND    = 2'd0,
    OP_ACK     = 2'd1,
    OP_TICK    = 2'd2,
    OP_INBOUND = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ACT_NEW   = 3'd0,
    ACT_ACKED = 3'd1,
    ACT_RETX  = 3'd2,
    ACT_LOST  = 3'd3,
    ACT_ECHO  = 3'd4
  } act_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMEOUT = 1'd0,
    REG_RETRY   = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    op_t              op;
    logic [NUM_W-1:0] num;
  } item_t;

  typedef struct packed {
    act_t                 action;
    logic [NUM_W-1:0]     seq;
    logic [ATTEMPT_W-1:0] attempt;
  } result_t;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] timeout_ticks;
    logic [RETRY_W-1:0]   retry_limit;
  } cfg_t;

endpackage

>>> sv/swr_in_reg.sv
// Input register holding one accepted beat until the engine consumes it.
module swr_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  swr_pkg::item_t item_in,
  input  logic           consume,
  output logic           valid,
  output swr_pkg::item_t item_out
);
  import swr_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (consume) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_in;
    end
  end

  assign valid    = valid_r;
  assign item_out = item_r;
endmodule

>>> sv/swr_engine.sv
// Sender state and per-beat decision logic.
module swr_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  swr_pkg::cfg_t      cfg,
  input  swr_pkg::item_t     item,
  input  logic               fire,
  output logic               has_res,
  output swr_pkg::result_t   res
);
  import swr_pkg::*;

  logic                 pending_active_r, pending_active_nxt;
  logic [NUM_W-1:0]     pending_sequence_r, pending_sequence_nxt;
  logic [NUM_W-1:0]     next_sequence_r, next_sequence_nxt;
  logic [RETRY_W-1:0]   retry_count_r, retry_count_nxt;
  logic [TIMEOUT_W-1:0] elapsed_ticks_r, elapsed_ticks_nxt;
  logic [TIMEOUT_W-1:0] elapsed_inc;
  logic [ATTEMPT_W-1:0] attempt_cur;

  assign elapsed_inc = (elapsed_ticks_r != ELAPSED_MAX) ? elapsed_ticks_r + 1'b1
                                                        : elapsed_ticks_r;
  assign attempt_cur = {1'b0, retry_count_r} + 1'b1;

  always_comb begin
    pending_active_nxt   = pending_active_r;
    pending_sequence_nxt = pending_sequence_r;
    next_sequence_nxt    = next_sequence_r;
    retry_count_nxt      = retry_count_r;
    elapsed_ticks_nxt    = elapsed_ticks_r;
    has_res              = 1'b0;
    res.action           = ACT_ECHO;
    res.seq              = item.num;
    res.attempt          = '0;
    case (item.op)
      OP_SEND: begin
        pending_active_nxt   = 1'b1;
        pending_sequence_nxt = next_sequence_r;
        next_sequence_nxt    = next_sequence_r + 1'b1;
        retry_count_nxt      = '0;
        elapsed_ticks_nxt    = '0;
        has_res              = 1'b1;
        res.action           = ACT_NEW;
        res.seq              = next_sequence_r;
        res.attempt          = ATTEMPT_W'(1);
      end
      OP_ACK: begin
        res.seq = pending_sequence_r;
        if (pending_active_r && (pending_sequence_r == item.num)) begin
          pending_active_nxt = 1'b0;
          has_res            = 1'b1;
          res.action         = ACT_ACKED;
          res.attempt        = attempt_cur;
        end
      end
      OP_TICK: begin
        res.seq = pending_sequence_r;
        if (pending_active_r) begin
          elapsed_ticks_nxt = elapsed_inc;
          if (elapsed_inc >= cfg.timeout_ticks) begin
            has_res = 1'b1;
            if (retry_count_r >= cfg.retry_limit) begin
              pending_active_nxt = 1'b0;
              res.action         = ACT_LOST;
              res.attempt        = attempt_cur;
            end else begin
              retry_count_nxt   = retry_count_r + 1'b1;
              elapsed_ticks_nxt = '0;
              res.action        = ACT_RETX;
              res.attempt       = attempt_cur + 1'b1;
            end
          end
        end
      end
      OP_INBOUND: begin
        has_res    = 1'b1;
        res.action = ACT_ECHO;
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_active_r   <= 1'b0;
      pending_sequence_r <= '0;
      next_sequence_r    <= SEQ_FIRST;
      retry_count_r      <= '0;
      elapsed_ticks_r    <= '0;
    end else if (fire) begin
      pending_active_r   <= pending_active_nxt;
      pending_sequence_r <= pending_sequence_nxt;
      next_sequence_r    <= next_sequence_nxt;
      retry_count_r      <= retry_count_nxt;
      elapsed_ticks_r    <= elapsed_ticks_nxt;
    end
  end
endmodule

>>> sv/swr_out_reg.sv
// Result register holding one beat until the downstream side takes it.
module swr_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  swr_pkg::result_t res_in,
  input  logic             taken,
  output logic             valid,
  output logic             free,
  output swr_pkg::result_t res_out
);
  import swr_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign free = !valid_r || taken;

  always_comb begin
    valid_nxt = valid_r;
    if (taken) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign valid   = valid_r;
  assign res_out = res_r;
endmodule

>>> sv/stop_and_wait_retransmit_core.sv
// Stop-and-wait sender: one beat in per cycle, each beat decided in a single
// pass between an input register and a result register. An accepted beat is
// held in the input register until decided, and its result (if any) is
// registered in the result register, which drives out_*; throughput is
// one beat per cycle for as long as out_tready stays high, and a beat that
// gives no result never waits for the result register. in_tready follows
// out_tready combinationally through the result register's free slot.
// Configuration writes take effect at the next edge and are meant for idle.
module stop_and_wait_retransmit_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_index,
  input  logic [15:0]              cfg_wdata,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [31:0]              in_tdata,   // [31:0] number_value
  input  logic [1:0]               in_tuser,   // [1:0] operation
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [39:0]              out_tdata,  // [31:0] sequence_out, [36:32] attempt_number
  output logic [2:0]               out_tuser   // [2:0] action
);
  import swr_pkg::*;
  `include "stop_and_wait_retransmit_core_defines.svh"

  cfg_t    cfg_r;
  item_t   in_item, s1_item;
  result_t eng_res, out_res;
  logic    s1_valid, has_res, out_free, adv, in_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks <= TIMEOUT_RST;
      cfg_r.retry_limit   <= RETRY_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TIMEOUT: cfg_r.timeout_ticks <= cfg_wdata;
        REG_RETRY:   cfg_r.retry_limit   <= cfg_wdata[RETRY_W-1:0];
        default:     cfg_r               <= cfg_r;
      endcase
    end
  end

  assign in_item.op  = op_t'(in_tuser);
  assign in_item.num = in_tdata;

  assign adv       = s1_valid && (!has_res || out_free);
  assign in_tready = !s1_valid || adv;
  assign in_fire   = in_tvalid && in_tready;

  swr_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_fire),
    .item_in  (in_item),
    .consume  (adv),
    .valid    (s1_valid),
    .item_out (s1_item)
  );

  swr_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .item    (s1_item),
    .fire    (adv),
    .has_res (has_res),
    .res     (eng_res)
  );

  swr_out_reg u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (adv && has_res),
    .res_in  (eng_res),
    .taken   (out_tvalid && out_tready),
    .valid   (out_tvalid),
    .free    (out_free),
    .res_out (out_res)
  );

  assign out_tdata = {3'b000, out_res.attempt, out_res.seq};
  assign out_tuser = out_res.action;

  `SWR_ASSERT_NEXT(a_res_reaches_out, adv && has_res, out_tvalid)
  `SWR_ASSERT_IMPL(a_stall_needs_item, !in_tready, s1_valid && has_res && !out_free)
  `SWR_ASSERT_IMPL(a_new_first_attempt, out_tvalid && (out_tuser == ACT_NEW),
                   out_tdata[36:32] == 5'd1)
endmodule

>>> tb/sv/swr_arq_checker.sv
// Stop-and-wait sender checker: predicts each result beat and compares it with the block.
module swr_arq_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic [2:0]  out_tuser,
  output int          mismatches,
  output int          outstanding
);
  import swr_pkg::*;

  result_t owed_results[$];
  int      errs = 0;

  logic                 msg_live;
  logic [NUM_W-1:0]     live_seq;
  logic [NUM_W-1:0]     seq_next;
  logic [RETRY_W-1:0]   retries;
  logic [RETRY_W-1:0]   retry_cap;
  logic [TIMEOUT_W-1:0] elapsed;
  logic [TIMEOUT_W-1:0] timeout;

  function automatic bit arq_step(op_t op, logic [NUM_W-1:0] num, output result_t r);
    logic [ATTEMPT_W-1:0] tries;
    r = '{action: ACT_ECHO, seq: num, attempt: '0};
    case (op)
      OP_SEND: begin
        msg_live = 1'b1;
        live_seq = seq_next;
        seq_next = seq_next + 1'b1;
        retries  = '0;
        elapsed  = '0;
        r = '{action: ACT_NEW, seq: live_seq, attempt: ATTEMPT_W'(1)};
        return 1'b1;
      end
      OP_ACK: begin
        if (!msg_live || live_seq != num) return 1'b0;
        msg_live = 1'b0;
        tries = ATTEMPT_W'(retries) + ATTEMPT_W'(1);
        r = '{action: ACT_ACKED, seq: live_seq, attempt: tries};
        return 1'b1;
      end
      OP_TICK: begin
        if (!msg_live) return 1'b0;
        if (elapsed != ELAPSED_MAX) elapsed = elapsed + 1'b1;
        if (elapsed < timeout) return 1'b0;
        if (retries >= retry_cap) begin
          msg_live = 1'b0;
          tries = ATTEMPT_W'(retries) + ATTEMPT_W'(1);
          r = '{action: ACT_LOST, seq: live_seq, attempt: tries};
          return 1'b1;
        end
        retries = retries + 1'b1;
        elapsed = '0;
        tries = ATTEMPT_W'(retries) + ATTEMPT_W'(1);
        r = '{action: ACT_RETX, seq: live_seq, attempt: tries};
        return 1'b1;
      end
      default: return 1'b1;
    endcase
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    result_t fresh;
    if (!rst_n) begin
      owed_results.delete();
      msg_live  = 1'b0;
      live_seq  = '0;
      seq_next  = SEQ_FIRST;
      retries   = '0;
      elapsed   = '0;
      timeout   = TIMEOUT_RST;
      retry_cap = RETRY_RST;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{action: act_t'(out_tuser), seq: out_tdata[31:0],
                attempt: out_tdata[36:32]};
        if (owed_results.size() == 0) begin
          errs++;
          $display("%0t: unexpected beat, expected none, got action %0d seq %h attempt %0d",
                   $time, got.action, got.seq, got.attempt);
        end else begin
          want = owed_results.pop_front();
          if (got.action !== want.action || got.seq !== want.seq
              || got.attempt !== want.attempt) begin
            errs++;
            $display({"%0t: expected action %0d seq %h attempt %0d,",
                      " got action %0d seq %h attempt %0d"},
                     $time, want.action, want.seq, want.attempt,
                     got.action, got.seq, got.attempt);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_TIMEOUT) timeout = cfg_wdata;
        else retry_cap = cfg_wdata[RETRY_W-1:0];
      end
      if (in_tvalid && in_tready) begin
        if (arq_step(op_t'(in_tuser), in_tdata, fresh)) owed_results.push_back(fresh);
      end
    end
    mismatches  <= errs;
    outstanding <= owed_results.size();
  end

endmodule

>>> tb/sv/testbench.sv
// Stop-and-wait sender testbench top: clock, reset, stimulus, back-pressure and verdict.
module testbench;
  import swr_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] number_value
  logic [1:0]  in_tuser;   // [1:0] operation
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [31:0] sequence_out, [36:32] attempt_number
  logic [2:0]  out_tuser;  // [2:0] action
  int          mismatches;
  int          outstanding;

  bit          calm;
  logic [31:0] next_num;
  logic [31:0] live_num;

  logic [15:0] phase_ticks[6] = '{16'd2, 16'd0, 16'd1, 16'd6, 16'hFFFF, 16'd500};
  logic [3:0]  phase_cap[6]   = '{4'd1, 4'd15, 4'd0, 4'd5, 4'd15, 4'd3};

  stop_and_wait_retransmit_core u_dut (.*);
  swr_arq_checker u_check (.*);

  always #5 clk = ~clk;

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic issue(op_t op, logic [31:0] num);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= num;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gap = gap_len();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_msg();
    live_num = next_num;
    next_num = next_num + 1;
    issue(OP_SEND, $urandom);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(logic [15:0] ticks, logic [3:0] cap);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TIMEOUT;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_index <= REG_RETRY;
    cfg_wdata <= {12'($urandom), cap};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int quota);
    int done;
    int steps;
    int pick;
    op_t op;
    done = 0;
    while (done < quota) begin
      if ($urandom_range(0, 24) == 0) calm = ~calm;
      if ($urandom_range(0, 9) < 7) begin
        send_msg();
        done++;
        steps = $urandom_range(1, 40);
        for (int k = 0; k < steps; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 55) begin
            issue(OP_TICK, $urandom);
            done++;
          end else if (pick < 72) begin
            issue(OP_ACK, live_num);
            done++;
            break;
          end else if (pick < 80) begin
            issue(OP_INBOUND, $urandom);
            done++;
          end else if (pick < 88) begin
            issue(OP_ACK, live_num ^ (32'd1 << $urandom_range(0, 31)));
            done++;
          end else if (pick < 94) begin
            send_msg();
            done++;
          end else begin
            issue(OP_ACK, live_num - 1);
            done++;
          end
        end
      end else begin
        op = op_t'($urandom_range(1, 3));
        issue(op, $urandom);
        done++;
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      int stall;
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      stall = gap_len();
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_TIMEOUT;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_SEND;
    calm      = 1'b0;
    next_num  = 32'd1;
    live_num  = 32'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle block, echo extremes, replace and acknowledge
    issue(OP_TICK, 32'hFFFF_FFFF);
    issue(OP_ACK, 32'd1);
    issue(OP_INBOUND, 32'h0000_0000);
    issue(OP_INBOUND, 32'hFFFF_FFFF);
    send_msg();
    issue(OP_ACK, live_num + 1);
    issue(OP_ACK, live_num);
    issue(OP_ACK, live_num);
    send_msg();
    send_msg();
    issue(OP_ACK, live_num - 1);
    issue(OP_ACK, live_num);
    settle();

    // zero timeout, no retries: first tick loses the link
    configure(16'd0, 4'd0);
    send_msg();
    issue(OP_TICK, 32'd0);
    issue(OP_TICK, 32'd0);
    settle();

    configure(16'd1, 4'd2);
    send_msg();
    repeat (3) issue(OP_TICK, $urandom);
    send_msg();
    issue(OP_TICK, $urandom);
    issue(OP_ACK, live_num);
    settle();

    // count out retransmit and loss tick by tick at full rate
    configure(16'd12, 4'd1);
    calm = 1'b1;
    send_msg();
    repeat (26) issue(OP_TICK, $urandom);
    calm = 1'b0;
    settle();

    for (int p = 0; p < 6; p++) begin
      configure(phase_ticks[p], phase_cap[p]);
      random_phase(300);
      settle();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
